/* hw/rtl/jkve_pkg.sv */
// Shared types and constants for the JSON key/value extractor.
package jkve_pkg;

    // Parser phase
    typedef enum logic [2:0] {
        PH_SEARCH = 3'd0,
        PH_QUOTE  = 3'd1,
        PH_COLON  = 3'd2,
        PH_VALUE  = 3'd3,
        PH_IGNORE = 3'd4
    } t_phase;

    // Result status codes
    typedef enum logic [2:0] {
        ST_MORE      = 3'd0,
        ST_COMPLETE  = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_BAD_FMT   = 3'd3,
        ST_UNTERM    = 3'd4
    } t_status;

    // Configuration register indexes
    localparam logic CFG_KEY_CHARS  = 1'b0;
    localparam logic CFG_KEY_LENGTH = 1'b1;

    localparam int KEY_BITS     = 64;
    localparam int KEY_LEN_BITS = 4;

    // Syntax characters
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_COMMA   = 8'h2C;

endpackage

/* hw/rtl/json_key_value_extractor.sv */
// JSON key/value extractor: finds a configured key and streams out its value.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------------------
//  in      | sink      | i_in_valid / o_in_stall   | i_doc_byte, i_doc_last
//  out     | source    | o_out_valid / i_out_stall | o_value_byte, o_byte_valid, o_status,
//          |           |                           | o_done_res
//  cfg     | sink      | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// One item per cycle sustained while the output is not stalled. An accepted item is
// held in the input register and parsed into the result register as it moves on,
// which offers any result it yields. The output register frees each cycle its item is
// taken; input stalls only while the input register holds an item that cannot move on.
// Reset (synchronous, active low) returns to key search with key 0 and key length 1.
module json_key_value_extractor #(
    parameter int MAX_KEY_LEN = 8,
    parameter int DEPTH_BITS  = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input items
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [7:0]                     i_doc_byte,
    input  logic                           i_doc_last,
    // result items
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [7:0]                     o_value_byte,
    output logic                           o_byte_valid,
    output logic [2:0]                     o_status,
    output logic                           o_done_res,
    // configuration
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [jkve_pkg::KEY_BITS-1:0]  i_cfg_data
);

    localparam logic [jkve_pkg::KEY_LEN_BITS-1:0] KLEN_MAX =
        jkve_pkg::KEY_LEN_BITS'(MAX_KEY_LEN);
    localparam logic signed [DEPTH_BITS-1:0] DMAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
    localparam logic signed [DEPTH_BITS-1:0] DMIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};

    // configuration registers
    logic [jkve_pkg::KEY_BITS-1:0]     r_key_chars;
    logic [jkve_pkg::KEY_LEN_BITS-1:0] r_key_length;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // parser state
    jkve_pkg::t_phase                  r_phase, n_phase;
    logic [jkve_pkg::KEY_LEN_BITS-1:0] r_match, n_match;
    logic signed [DEPTH_BITS-1:0]      r_depth, n_depth;

    // result register
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_bvalid;
    logic [2:0] r_out_status;
    logic       r_out_done;

    // combinational result
    logic       c_emit;
    logic [7:0] c_byte;
    logic       c_bvalid;
    jkve_pkg::t_status c_status;
    logic       c_done;

    logic                              out_free;
    logic                              advance;
    logic [jkve_pkg::KEY_LEN_BITS-1:0] klen;
    logic [7:0]                        key_byte;
    logic [jkve_pkg::KEY_LEN_BITS-1:0] match_try;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    // effective key length: 0 reads as 1, capped at the maximum
    always_comb begin
        if (r_key_length == '0) begin
            klen = jkve_pkg::KEY_LEN_BITS'(1);
        end else if (r_key_length > KLEN_MAX) begin
            klen = KLEN_MAX;
        end else begin
            klen = r_key_length;
        end
    end

    assign key_byte = r_key_chars[{r_match[2:0], 3'b000} +: 8];

    // next state and result for the item in the input register
    always_comb begin
        n_phase   = r_phase;
        n_match   = r_match;
        n_depth   = r_depth;
        c_emit    = 1'b0;
        c_byte    = 8'h00;
        c_bvalid  = 1'b0;
        c_status  = jkve_pkg::ST_MORE;
        c_done    = 1'b0;
        match_try = '0;

        case (r_phase)
            jkve_pkg::PH_SEARCH: begin
                if ((r_match < klen) && (r_in_byte == key_byte)) begin
                    match_try = r_match + 1'b1;
                end
                n_match = match_try;
                if (match_try >= klen) begin
                    n_phase = jkve_pkg::PH_QUOTE;
                    if (r_in_last) begin
                        c_emit   = 1'b1;
                        c_status = jkve_pkg::ST_BAD_FMT;
                        c_done   = 1'b1;
                    end
                end else if (r_in_last) begin
                    c_emit   = 1'b1;
                    c_status = jkve_pkg::ST_NOT_FOUND;
                    c_done   = 1'b1;
                end
            end
            jkve_pkg::PH_QUOTE: begin
                if ((r_in_byte != jkve_pkg::CH_QUOTE) || r_in_last) begin
                    n_phase  = jkve_pkg::PH_IGNORE;
                    c_emit   = 1'b1;
                    c_status = jkve_pkg::ST_BAD_FMT;
                    c_done   = 1'b1;
                end else begin
                    n_phase = jkve_pkg::PH_COLON;
                end
            end
            jkve_pkg::PH_COLON: begin
                if (r_in_byte != jkve_pkg::CH_COLON) begin
                    n_phase  = jkve_pkg::PH_IGNORE;
                    c_emit   = 1'b1;
                    c_status = jkve_pkg::ST_BAD_FMT;
                    c_done   = 1'b1;
                end else begin
                    n_phase = jkve_pkg::PH_VALUE;
                    n_depth = '0;
                    if (r_in_last) begin
                        c_emit   = 1'b1;
                        c_status = jkve_pkg::ST_UNTERM;
                        c_done   = 1'b1;
                    end
                end
            end
            jkve_pkg::PH_VALUE: begin
                if ((r_depth == '0) && ((r_in_byte == jkve_pkg::CH_RBRACE) ||
                                        (r_in_byte == jkve_pkg::CH_COMMA))) begin
                    n_phase  = jkve_pkg::PH_IGNORE;
                    c_emit   = 1'b1;
                    c_status = jkve_pkg::ST_COMPLETE;
                    c_done   = 1'b1;
                end else begin
                    // saturating nesting depth
                    if ((r_in_byte == jkve_pkg::CH_LBRACE) ||
                        (r_in_byte == jkve_pkg::CH_LBRACK)) begin
                        if (r_depth != DMAX) n_depth = r_depth + 1'b1;
                    end else if ((r_in_byte == jkve_pkg::CH_RBRACE) ||
                                 (r_in_byte == jkve_pkg::CH_RBRACK)) begin
                        if (r_depth != DMIN) n_depth = r_depth - 1'b1;
                    end
                    c_emit   = 1'b1;
                    c_byte   = r_in_byte;
                    c_bvalid = 1'b1;
                    c_status = r_in_last ? jkve_pkg::ST_UNTERM : jkve_pkg::ST_MORE;
                    c_done   = r_in_last;
                end
            end
            default: begin
                // ignoring until the end of the document
            end
        endcase

        // end of document: back to key search
        if (r_in_last) begin
            n_phase = jkve_pkg::PH_SEARCH;
            n_match = '0;
            n_depth = '0;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_chars  <= '0;
            r_key_length <= jkve_pkg::KEY_LEN_BITS'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                jkve_pkg::CFG_KEY_CHARS:  r_key_chars  <= i_cfg_data;
                jkve_pkg::CFG_KEY_LENGTH:
                    r_key_length <= i_cfg_data[jkve_pkg::KEY_LEN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_doc_byte;
            r_in_last <= i_doc_last;
        end
    end

    // parser state, updated as each item moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= jkve_pkg::PH_SEARCH;
            r_match <= '0;
            r_depth <= '0;
        end else if (advance) begin
            r_phase <= n_phase;
            r_match <= n_match;
            r_depth <= n_depth;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid && c_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte   <= c_byte;
            r_out_bvalid <= c_bvalid;
            r_out_status <= c_status;
            r_out_done   <= c_done;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_value_byte = r_out_byte;
    assign o_byte_valid = r_out_bvalid;
    assign o_status     = r_out_status;
    assign o_done_res   = r_out_done;

endmodule

/* sim/tb_top.sv */
// Testbench for json_key_value_extractor: random JSON byte streams, predicted results.
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_KEY     = 8;
    localparam int HOLD_CYCLES = 150;
    localparam int ITEMS_PER_KEY = 70;
    localparam logic signed [7:0] DEPTH_TOP    = 8'sh7F;
    localparam logic signed [7:0] DEPTH_BOTTOM = 8'sh80;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
    } t_doc_item;

    typedef struct {
        logic [7:0]        value;
        logic              bvalid;
        jkve_pkg::t_status status;
        logic              done;
    } t_extract_res;

    // DUT ports
    logic                          i_clk        = 1'b0;
    logic                          i_rst_n      = 1'b0;
    logic                          i_in_valid   = 1'b0;
    logic                          o_in_stall;
    logic [7:0]                    i_doc_byte   = 8'h00;
    logic                          i_doc_last   = 1'b0;
    logic                          o_out_valid;
    logic                          i_out_stall  = 1'b0;
    logic [7:0]                    o_value_byte;
    logic                          o_byte_valid;
    logic [2:0]                    o_status;
    logic                          o_done_res;
    logic                          i_cfg_we     = 1'b0;
    logic                          i_cfg_index  = jkve_pkg::CFG_KEY_CHARS;
    logic [jkve_pkg::KEY_BITS-1:0] i_cfg_data   = '0;

    // Parser copy: configuration and state as they stand after reset
    logic [63:0]       key_reg     = '0;
    logic [3:0]        key_len_reg = 4'd1;
    jkve_pkg::t_phase  ph          = jkve_pkg::PH_SEARCH;
    logic [3:0]        match_cnt   = '0;
    logic signed [7:0] depth       = '0;

    t_doc_item    pending[$];
    t_extract_res expected[$];
    logic [7:0]   doc[$];

    int n_sent     = 0;
    int n_accepted = 0;
    int n_errors   = 0;
    int send_idle  = 30;
    int recv_idle  = 60;
    int hold_reqs  = 0;
    int hold_seen  = 0;
    int hold_left  = 0;

    always #4 i_clk = ~i_clk;

    json_key_value_extractor #(
        .MAX_KEY_LEN (MAX_KEY),
        .DEPTH_BITS  (8)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_doc_byte   (i_doc_byte),
        .i_doc_last   (i_doc_last),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_value_byte (o_value_byte),
        .o_byte_valid (o_byte_valid),
        .o_status     (o_status),
        .o_done_res   (o_done_res),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    task automatic report(input string msg);
        if (n_errors < 50) begin
            $display("ERROR at %0t ns: %s", $time, msg);
        end
        n_errors++;
    endtask

    // Effective key length: 0 counts as 1, anything past the maximum is clamped
    function automatic logic [3:0] key_span();
        if (key_len_reg == 0) return 4'd1;
        if (key_len_reg > MAX_KEY) return 4'(MAX_KEY);
        return key_len_reg;
    endfunction

    // Advance the parser copy by one document byte; returns 1 if a result is due
    function automatic bit extract_step(input logic [7:0] b, input logic last,
                                        output t_extract_res r);
        logic [3:0] klen;
        logic [7:0] kb;
        bit         hit;
        hit      = 1'b0;
        r.value  = 8'h00;
        r.bvalid = 1'b0;
        r.status = jkve_pkg::ST_MORE;
        r.done   = 1'b0;
        klen     = key_span();
        case (ph)
            jkve_pkg::PH_SEARCH: begin
                kb = key_reg[8*match_cnt[2:0] +: 8];
                // naive match: a miss drops to zero without rechecking the byte
                if (match_cnt < klen && b == kb) match_cnt = match_cnt + 4'd1;
                else match_cnt = '0;
                if (match_cnt >= klen) begin
                    ph = jkve_pkg::PH_QUOTE;
                    if (last) begin
                        hit      = 1'b1;
                        r.status = jkve_pkg::ST_BAD_FMT;
                    end
                end else if (last) begin
                    hit      = 1'b1;
                    r.status = jkve_pkg::ST_NOT_FOUND;
                end
            end
            jkve_pkg::PH_QUOTE: begin
                if (b != jkve_pkg::CH_QUOTE || last) begin
                    ph       = jkve_pkg::PH_IGNORE;
                    hit      = 1'b1;
                    r.status = jkve_pkg::ST_BAD_FMT;
                end else begin
                    ph = jkve_pkg::PH_COLON;
                end
            end
            jkve_pkg::PH_COLON: begin
                if (b != jkve_pkg::CH_COLON) begin
                    ph       = jkve_pkg::PH_IGNORE;
                    hit      = 1'b1;
                    r.status = jkve_pkg::ST_BAD_FMT;
                end else begin
                    ph    = jkve_pkg::PH_VALUE;
                    depth = '0;
                    if (last) begin
                        hit      = 1'b1;
                        r.status = jkve_pkg::ST_UNTERM;
                    end
                end
            end
            jkve_pkg::PH_VALUE: begin
                if (depth == 0 && (b == jkve_pkg::CH_RBRACE || b == jkve_pkg::CH_COMMA)) begin
                    ph       = jkve_pkg::PH_IGNORE;
                    hit      = 1'b1;
                    r.status = jkve_pkg::ST_COMPLETE;
                end else begin
                    // saturating nesting depth
                    if (b == jkve_pkg::CH_LBRACE || b == jkve_pkg::CH_LBRACK) begin
                        if (depth != DEPTH_TOP) depth = depth + 8'sd1;
                    end else if (b == jkve_pkg::CH_RBRACE || b == jkve_pkg::CH_RBRACK) begin
                        if (depth != DEPTH_BOTTOM) depth = depth - 8'sd1;
                    end
                    hit      = 1'b1;
                    r.value  = b;
                    r.bvalid = 1'b1;
                    if (last) r.status = jkve_pkg::ST_UNTERM;
                end
            end
            default: ;
        endcase
        r.done = hit && (r.status != jkve_pkg::ST_MORE);
        if (last) begin
            ph        = jkve_pkg::PH_SEARCH;
            match_cnt = '0;
            depth     = '0;
        end
        return hit;
    endfunction

    // Driver: offers pending items, predicts each accepted one
    always @(posedge i_clk) begin : p_drive
        t_extract_res r;
        t_doc_item    nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                n_accepted <= n_accepted + 1;
                if (extract_step(i_doc_byte, i_doc_last, r)) expected.insert(expected.size(), r);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending.size() != 0 && $urandom_range(99) >= send_idle) begin
                    nxt = pending.pop_front();
                    i_in_valid <= 1'b1;
                    i_doc_byte <= nxt.b;
                    i_doc_last <= nxt.last;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall: random, or a long hold-off when one is requested
    always @(posedge i_clk) begin : p_stall
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_reqs != hold_seen) begin
            hold_seen   <= hold_seen + 1;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    // Monitor: compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin : p_check
        t_extract_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected.size() == 0) begin
                report($sformatf("unexpected result byte %02h valid %0b status %0d done %0b",
                                 o_value_byte, o_byte_valid, o_status, o_done_res));
            end else begin
                want = expected.pop_front();
                if (o_value_byte !== want.value || o_byte_valid !== want.bvalid ||
                    o_status !== want.status || o_done_res !== want.done) begin
                    report($sformatf({"got byte %02h valid %0b status %0d done %0b, ",
                                      "want byte %02h valid %0b status %0d done %0b"},
                                     o_value_byte, o_byte_valid, o_status, o_done_res,
                                     want.value, want.bvalid, want.status, want.done));
                end
            end
        end
    end

    task automatic write_reg(input logic idx, input logic [63:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == jkve_pkg::CFG_KEY_CHARS) key_reg = data;
        else key_len_reg = data[3:0];
    endtask

    // Append one byte to the document being built
    task automatic add_byte(input logic [7:0] b);
        doc.insert(doc.size(), b);
    endtask

    // Queue the current document as items, last flag on its final byte
    task automatic push_doc();
        for (int i = 0; i < doc.size(); i++) begin
            pending.insert(pending.size(), t_doc_item'{doc[i], i == doc.size() - 1});
        end
        n_sent += doc.size();
    endtask

    // Wait for all items to be taken and all results to arrive
    task automatic drain();
        int waited;
        while (n_accepted != n_sent) @(negedge i_clk);
        waited = 0;
        while (expected.size() != 0 && waited < 1000) begin
            @(negedge i_clk);
            waited++;
        end
        if (expected.size() != 0) begin
            report($sformatf("%0d expected results never arrived", expected.size()));
            expected.delete();
        end
        repeat (4) @(negedge i_clk);
    endtask

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(3))
            0:       return 8'h61;
            1:       return 8'h62;
            2:       return key_reg[8*$urandom_range(7) +: 8];
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] value_char();
        case ($urandom_range(11))
            0:       return jkve_pkg::CH_LBRACE;
            1:       return jkve_pkg::CH_LBRACK;
            2:       return jkve_pkg::CH_RBRACK;
            3:       return jkve_pkg::CH_RBRACE;
            4:       return jkve_pkg::CH_COMMA;
            5:       return jkve_pkg::CH_QUOTE;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic key_prefix();
        for (int i = 0; i < key_span(); i++) add_byte(key_reg[8*i +: 8]);
        add_byte(jkve_pkg::CH_QUOTE);
        add_byte(jkve_pkg::CH_COLON);
    endtask

    // Mostly well-formed documents; some cut short or with one byte corrupted
    task automatic make_doc();
        int n;
        doc.delete();
        n = $urandom_range(4);
        repeat (n) add_byte(noise_byte());
        key_prefix();
        n = $urandom_range(10);
        repeat (n) add_byte(value_char());
        add_byte($urandom_range(1) ? jkve_pkg::CH_RBRACE : jkve_pkg::CH_COMMA);
        n = $urandom_range(3);
        repeat (n) add_byte(noise_byte());
        case ($urandom_range(9))
            0, 1: begin
                n = $urandom_range(doc.size() - 1);
                while (doc.size() > n + 1) void'(doc.pop_back());
            end
            2: doc[$urandom_range(doc.size() - 1)] = 8'($urandom_range(255));
            default: ;
        endcase
        push_doc();
    endtask

    // Value nested past both depth limits, left open at the last byte
    task automatic deep_doc();
        doc.delete();
        key_prefix();
        repeat (130) add_byte(jkve_pkg::CH_LBRACK);
        repeat (260) add_byte(jkve_pkg::CH_RBRACK);
        repeat (3) add_byte(jkve_pkg::CH_LBRACE);
        repeat (2) add_byte(jkve_pkg::CH_RBRACE);
        add_byte(8'h78);
        push_doc();
    endtask

    // One key setting followed by a batch of random documents
    task automatic run_setting(input int s);
        logic [63:0] key;
        logic [3:0]  len;
        int          start;
        bit          paused;
        for (int i = 0; i < 8; i++) begin
            if (s % 3 == 0) key[8*i +: 8] = $urandom_range(1) ? 8'h61 : 8'h62;
            else key[8*i +: 8] = 8'($urandom_range(255));
        end
        if (s == 4) key = '1;
        if (s == 7) key = '0;
        case (s % 4)
            0:       len = 4'd1;
            1:       len = 4'd8;
            2:       len = (s == 2) ? 4'd0 : (s == 6) ? 4'd15 : 4'($urandom_range(9, 15));
            default: len = 4'($urandom_range(2, 7));
        endcase
        write_reg(jkve_pkg::CFG_KEY_LENGTH, {60'b0, len});
        write_reg(jkve_pkg::CFG_KEY_CHARS, key);
        @(negedge i_clk);
        if (s == 10) deep_doc();
        start  = n_sent;
        paused = 1'b0;
        while (n_sent - start < ITEMS_PER_KEY) begin
            make_doc();
            // sender pause: let every result come back before going on
            if (s == 1 && !paused && n_sent - start >= ITEMS_PER_KEY / 2) begin
                drain();
                paused = 1'b1;
            end
        end
        // long receiver hold-off while the sender keeps offering
        if (s == 9) hold_reqs++;
        drain();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed document under the reset key (0x00, length 1)
        doc = '{8'h00, jkve_pkg::CH_QUOTE, jkve_pkg::CH_COLON, 8'hFF};
        push_doc();
        drain();
        write_reg(jkve_pkg::CFG_KEY_LENGTH, 64'd2);
        write_reg(jkve_pkg::CFG_KEY_CHARS, 64'h6261);
        @(negedge i_clk);
        doc = '{8'h61, 8'h61, 8'h62};                                  // miss does not recheck
        push_doc();
        doc = '{8'h61, 8'h62};                                         // key at last byte
        push_doc();
        doc = '{8'h61, 8'h62, 8'h78, jkve_pkg::CH_QUOTE};              // wrong quote
        push_doc();
        doc = '{8'h61, 8'h62, jkve_pkg::CH_QUOTE, 8'h78};              // wrong colon
        push_doc();
        doc = '{8'h61, 8'h62, jkve_pkg::CH_QUOTE, jkve_pkg::CH_COLON}; // colon last
        push_doc();
        doc = '{8'h61, 8'h62, jkve_pkg::CH_QUOTE, jkve_pkg::CH_COLON,
                jkve_pkg::CH_LBRACK, jkve_pkg::CH_RBRACK, jkve_pkg::CH_RBRACK,
                jkve_pkg::CH_LBRACE, jkve_pkg::CH_COMMA};              // comma at depth zero
        push_doc();
        drain();

        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin
                    send_idle = 30;
                    recv_idle = 60;
                end
                1: begin
                    send_idle = 60;
                    recv_idle = 30;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            for (int k = 0; k < 4; k++) run_setting(4 * p + k);
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/jkve_pkg.sv
hw/rtl/json_key_value_extractor.sv
sim/tb_top.sv
